FILE: design/ucrb_pkg.sv
// ----------------------------------------------------------------------------
// ucrb_pkg
// Shared types and constants for the buffered UART front end: request
// formats, action and status codes, line characters and ring status.
// ----------------------------------------------------------------------------
`default_nettype none

package ucrb_pkg;

    localparam int DATA_W = 8;
    localparam int LVL_W  = 6;

    // Action codes
    localparam logic [1:0] ACT_LINE_RX = 2'd0;
    localparam logic [1:0] ACT_HOST_WR = 2'd1;
    localparam logic [1:0] ACT_HOST_RD = 2'd2;
    localparam logic [1:0] ACT_TX_RDY  = 2'd3;

    // Status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic [DATA_W-1:0] CHAR_CR = 8'h0d;
    localparam logic [DATA_W-1:0] CHAR_LF = 8'h0a;

    typedef struct packed {
        logic [1:0]        action;
        logic [DATA_W-1:0] data_in;
    } t_in_req;

    typedef struct packed {
        logic [1:0]        status;
        logic [DATA_W-1:0] data_out;
        logic [LVL_W-1:0]  rx_level;
        logic [LVL_W-1:0]  tx_level;
        logic              rx_irq_enable;
        logic              tx_irq_enable;
    } t_out_req;

    typedef struct packed {
        logic             empty;
        logic             full;
        logic             room2;
        logic [LVL_W-1:0] level;
    } t_ring_stat;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LF,
        S_RD,
        S_HOLD
    } t_state;

endpackage

`default_nettype wire

FILE: design/ucrb_ram.sv
// ----------------------------------------------------------------------------
// ucrb_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ucrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: design/ucrb_ring.sv
// ----------------------------------------------------------------------------
// ucrb_ring
// One byte ring: head and tail pointers around a RAM, one slot kept free.
// Reports status before and after this cycle's push or pop.
// ----------------------------------------------------------------------------
`default_nettype none

module ucrb_ring #(
    parameter int DEPTH = 64
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_push,
    input  wire logic [ucrb_pkg::DATA_W-1:0] i_push_data,
    input  wire logic                        i_pop,
    output logic      [ucrb_pkg::DATA_W-1:0] o_rd_data,
    output ucrb_pkg::t_ring_stat             o_stat_now,
    output ucrb_pkg::t_ring_stat             o_stat_next
);

    import ucrb_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST    = AW'(DEPTH - 1);
    localparam logic [AW:0]   DEPTH_E = (AW + 1)'(DEPTH);
    localparam logic [AW+1:0] DEPTH_W = (AW + 2)'(DEPTH);

    logic [AW-1:0] r_head, r_tail;
    logic [AW-1:0] n_head, n_tail;

    function automatic logic [AW-1:0] adv(input logic [AW-1:0] p);
        adv = (p == LAST) ? '0 : p + AW'(1);
    endfunction

    function automatic t_ring_stat stat_of(input logic [AW-1:0] h,
                                           input logic [AW-1:0] t);
        logic [AW:0]   diff;
        logic [AW-1:0] lvl;
        t_ring_stat    s;
        diff = {1'b0, t} - {1'b0, h};
        if (diff[AW]) begin
            diff = diff + DEPTH_E;
        end
        lvl     = diff[AW-1:0];
        s.empty = (h == t);
        s.full  = (adv(t) == h);
        s.room2 = (((AW + 2)'(lvl)) + (AW + 2)'(2)) < DEPTH_W;
        s.level = LVL_W'(lvl);
        stat_of = s;
    endfunction

    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        if (i_push) begin
            n_tail = adv(r_tail);
        end
        if (i_pop) begin
            n_head = adv(r_head);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
        end
    end

    assign o_stat_now  = stat_of(r_head, r_tail);
    assign o_stat_next = stat_of(n_head, n_tail);

    ucrb_ram #(
        .WIDTH(DATA_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_push),
        .i_waddr (r_tail),
        .i_wdata (i_push_data),
        .i_re    (i_pop),
        .i_raddr (r_head),
        .o_rdata (o_rd_data)
    );

endmodule

`default_nettype wire

FILE: design/uart_crlf_ring_buffers.sv
// ----------------------------------------------------------------------------
// uart_crlf_ring_buffers
// Buffered UART front end: a receive ring and a transmit ring in RAM.
//
// Input channel (i_in_valid / o_in_stall / i_in_req) carries one action per
// request: line byte received, host write, host read or transmitter ready.
// Output channel (o_out_valid / i_out_stall / o_out_req) returns exactly one
// result request per action: status, byte read or sent, both ring levels and
// the two interrupt enables, all as they stand after the action.
// Line byte, plain host write and any refused or empty action finish in
// S_IDLE; host read, transmitter tick and a LF write (which stores CR then
// LF through the one RAM write port) pass first through S_RD or S_LF.
// Throughput: one request per cycle for actions that finish in S_IDLE while
// the output does not stall; o_in_stall is high while an action is still in
// flight. A read waits in S_RD for the registered RAM read data.
// A finished result waits in the output register while the receiver stalls;
// a new request is still taken, and its result is parked in a holding
// register, after which input stalls until the output register drains.
// Reset (synchronous, active low) empties both rings and drops any result.
// Store contents are not cleared: only entries between head and tail are read.
// ----------------------------------------------------------------------------
`default_nettype none

module uart_crlf_ring_buffers #(
    parameter int RX_DEPTH = 64,
    parameter int TX_DEPTH = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire ucrb_pkg::t_in_req  i_in_req,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output ucrb_pkg::t_out_req      o_out_req
);

    import ucrb_pkg::*;

    t_state   r_state, n_state;
    t_out_req r_out, r_pend, res;
    logic     r_out_valid;
    logic     r_rd_rx;

    logic in_fire, out_free;
    logic fin, lf_start, rd_start;
    logic [1:0]        res_status;
    logic [DATA_W-1:0] res_data;

    logic              rx_push, rx_pop, tx_push, tx_pop;
    logic [DATA_W-1:0] tx_wdata;
    logic [DATA_W-1:0] rx_rd, tx_rd;
    t_ring_stat        rx_now, rx_next, tx_now, tx_next;

    // Take a request only when no earlier one is still in flight.
    assign o_in_stall = (r_state != S_IDLE);
    assign in_fire    = i_in_valid && !o_in_stall;
    // Output register can take a result this cycle.
    assign out_free   = !r_out_valid || !i_out_stall;

    // Decode the action, drive the rings and form the result.
    always_comb begin
        fin        = 1'b0;
        lf_start   = 1'b0;
        rd_start   = 1'b0;
        res_status = ST_DONE;
        res_data   = '0;
        rx_push    = 1'b0;
        rx_pop     = 1'b0;
        tx_push    = 1'b0;
        tx_pop     = 1'b0;
        tx_wdata   = i_in_req.data_in;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    case (i_in_req.action)
                        ACT_LINE_RX: begin
                            fin = 1'b1;
                            if (rx_now.full) begin
                                res_status = ST_FULL;
                            end else begin
                                rx_push = 1'b1;
                            end
                        end
                        ACT_HOST_WR: begin
                            if (i_in_req.data_in == CHAR_LF) begin
                                // LF needs room for CR as well: refuse whole
                                if (!tx_now.room2) begin
                                    fin        = 1'b1;
                                    res_status = ST_FULL;
                                end else begin
                                    tx_push  = 1'b1;
                                    tx_wdata = CHAR_CR;
                                    lf_start = 1'b1;
                                end
                            end else begin
                                fin = 1'b1;
                                if (tx_now.full) begin
                                    res_status = ST_FULL;
                                end else begin
                                    tx_push = 1'b1;
                                end
                            end
                        end
                        ACT_HOST_RD: begin
                            if (rx_now.empty) begin
                                fin        = 1'b1;
                                res_status = ST_EMPTY;
                            end else begin
                                rx_pop   = 1'b1;
                                rd_start = 1'b1;
                            end
                        end
                        default: begin
                            if (tx_now.empty) begin
                                fin        = 1'b1;
                                res_status = ST_EMPTY;
                            end else begin
                                tx_pop   = 1'b1;
                                rd_start = 1'b1;
                            end
                        end
                    endcase
                end
            end
            S_LF: begin
                tx_push  = 1'b1;
                tx_wdata = CHAR_LF;
                fin      = 1'b1;
            end
            S_RD: begin
                fin = 1'b1;
                if (r_rd_rx) begin
                    // Host sees CR as LF
                    res_data = (rx_rd == CHAR_CR) ? CHAR_LF : rx_rd;
                end else begin
                    res_data = tx_rd;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        res.status        = res_status;
        res.data_out      = res_data;
        res.rx_level      = rx_next.level;
        res.tx_level      = tx_next.level;
        res.rx_irq_enable = !rx_next.full;
        res.tx_irq_enable = !tx_next.empty;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (lf_start) begin
                    n_state = S_LF;
                end else if (rd_start) begin
                    n_state = S_RD;
                end else if (fin && !out_free) begin
                    n_state = S_HOLD;
                end
            end
            S_LF, S_RD: begin
                n_state = out_free ? S_IDLE : S_HOLD;
            end
            S_HOLD: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (fin && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_state == S_HOLD && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload: advance result into the output register, or park it.
    always_ff @(posedge i_clk) begin
        if (fin && out_free) begin
            r_out <= res;
        end else if (r_state == S_HOLD && out_free) begin
            r_out <= r_pend;
        end
        if (fin && !out_free) begin
            r_pend <= res;
        end
        if (rd_start) begin
            r_rd_rx <= (i_in_req.action == ACT_HOST_RD);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

    ucrb_ring #(
        .DEPTH(RX_DEPTH)
    ) u_rx_ring (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (rx_push),
        .i_push_data (i_in_req.data_in),
        .i_pop       (rx_pop),
        .o_rd_data   (rx_rd),
        .o_stat_now  (rx_now),
        .o_stat_next (rx_next)
    );

    ucrb_ring #(
        .DEPTH(TX_DEPTH)
    ) u_tx_ring (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (tx_push),
        .i_push_data (tx_wdata),
        .i_pop       (tx_pop),
        .o_rd_data   (tx_rd),
        .o_stat_now  (tx_now),
        .o_stat_next (tx_next)
    );

endmodule

`default_nettype wire

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the buffered UART front end. It drives line bytes,
// host writes, host reads and transmitter ticks through the request channel.
// A predictor of both rings computes the result of every request, and each
// result is checked field by field against the oldest expected result.
// The run has a directed table and then three random phases that change
// which side idles. Random requests come in segments that lean towards
// filling or draining the rings, so both rings reach full, empty and wrap.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import ucrb_pkg::*;

    localparam int RING_DEPTH = 64;
    localparam int WATCHDOG   = 200000;
    localparam int NDIR       = 29;

    // One row of the directed table: a request, how often to repeat it, and
    // optionally a result typed in by hand
    typedef struct packed {
        logic [1:0]        action;
        logic [DATA_W-1:0] data_in;
        logic [6:0]        reps;
        logic              typed;
        t_out_req          want;
    } t_dir_row;

    logic     i_clk       = 1'b0;
    logic     i_rst_n     = 1'b0;
    logic     i_in_valid  = 1'b0;
    t_in_req  i_in_req    = '0;
    logic     i_out_stall = 1'b0;
    logic     o_in_stall;
    logic     o_out_valid;
    t_out_req o_out_req;

    // Predictor state: both rings with their own pointers; depth is a power
    // of two, so six-bit pointers wrap by themselves
    logic [DATA_W-1:0] rx_mem [RING_DEPTH];
    logic [DATA_W-1:0] tx_mem [RING_DEPTH];
    logic [LVL_W-1:0]  rx_rd = '0;
    logic [LVL_W-1:0]  rx_wr = '0;
    logic [LVL_W-1:0]  tx_rd = '0;
    logic [LVL_W-1:0]  tx_wr = '0;

    t_out_req expected_results [$];

    int in_idle_pct  = 0;
    int out_idle_pct = 0;
    int err_cnt      = 0;
    int checked_cnt  = 0;
    int full_cnt     = 0;
    int empty_cnt    = 0;
    int action_cnt [4];

    // Directed table: reset state, field extremes, CR/LF handling on both
    // sides, both rings filled to full with refusals, LF refused whole when
    // only one slot is free, drained to empty, then a wrapped read
    localparam t_dir_row DIR_TAB [NDIR] = '{
        '{ACT_HOST_RD, 8'h5a,   7'd1,  1'b1, '{ST_EMPTY, 8'h00,   6'd0,  6'd0,  1'b1, 1'b0}},
        '{ACT_TX_RDY,  8'ha5,   7'd1,  1'b1, '{ST_EMPTY, 8'h00,   6'd0,  6'd0,  1'b1, 1'b0}},
        '{ACT_LINE_RX, 8'h00,   7'd1,  1'b1, '{ST_DONE,  8'h00,   6'd1,  6'd0,  1'b1, 1'b0}},
        '{ACT_LINE_RX, 8'hff,   7'd1,  1'b1, '{ST_DONE,  8'h00,   6'd2,  6'd0,  1'b1, 1'b0}},
        '{ACT_LINE_RX, CHAR_CR, 7'd1,  1'b1, '{ST_DONE,  8'h00,   6'd3,  6'd0,  1'b1, 1'b0}},
        '{ACT_HOST_RD, 8'hff,   7'd1,  1'b1, '{ST_DONE,  8'h00,   6'd2,  6'd0,  1'b1, 1'b0}},
        '{ACT_HOST_RD, 8'h00,   7'd1,  1'b1, '{ST_DONE,  8'hff,   6'd1,  6'd0,  1'b1, 1'b0}},
        '{ACT_HOST_RD, 8'h00,   7'd1,  1'b1, '{ST_DONE,  CHAR_LF, 6'd0,  6'd0,  1'b1, 1'b0}},
        '{ACT_HOST_RD, 8'h00,   7'd1,  1'b1, '{ST_EMPTY, 8'h00,   6'd0,  6'd0,  1'b1, 1'b0}},
        '{ACT_HOST_WR, CHAR_LF, 7'd1,  1'b1, '{ST_DONE,  8'h00,   6'd0,  6'd2,  1'b1, 1'b1}},
        '{ACT_HOST_WR, 8'hff,   7'd1,  1'b1, '{ST_DONE,  8'h00,   6'd0,  6'd3,  1'b1, 1'b1}},
        '{ACT_HOST_WR, CHAR_CR, 7'd1,  1'b1, '{ST_DONE,  8'h00,   6'd0,  6'd4,  1'b1, 1'b1}},
        '{ACT_HOST_WR, 8'h00,   7'd1,  1'b1, '{ST_DONE,  8'h00,   6'd0,  6'd5,  1'b1, 1'b1}},
        '{ACT_TX_RDY,  8'hff,   7'd1,  1'b1, '{ST_DONE,  CHAR_CR, 6'd0,  6'd4,  1'b1, 1'b1}},
        '{ACT_TX_RDY,  8'h00,   7'd1,  1'b1, '{ST_DONE,  CHAR_LF, 6'd0,  6'd3,  1'b1, 1'b1}},
        '{ACT_TX_RDY,  8'h00,   7'd1,  1'b1, '{ST_DONE,  8'hff,   6'd0,  6'd2,  1'b1, 1'b1}},
        '{ACT_TX_RDY,  8'h00,   7'd1,  1'b1, '{ST_DONE,  CHAR_CR, 6'd0,  6'd1,  1'b1, 1'b1}},
        '{ACT_TX_RDY,  8'h00,   7'd1,  1'b1, '{ST_DONE,  8'h00,   6'd0,  6'd0,  1'b1, 1'b0}},
        '{ACT_TX_RDY,  8'h00,   7'd1,  1'b1, '{ST_EMPTY, 8'h00,   6'd0,  6'd0,  1'b1, 1'b0}},
        '{ACT_LINE_RX, 8'h3c,   7'd63, 1'b0, '0},
        '{ACT_LINE_RX, 8'h3d,   7'd1,  1'b1, '{ST_FULL,  8'h00,   6'd63, 6'd0,  1'b0, 1'b0}},
        '{ACT_HOST_WR, 8'h41,   7'd62, 1'b0, '0},
        '{ACT_HOST_WR, CHAR_LF, 7'd1,  1'b1, '{ST_FULL,  8'h00,   6'd63, 6'd62, 1'b0, 1'b1}},
        '{ACT_HOST_WR, 8'h42,   7'd1,  1'b1, '{ST_DONE,  8'h00,   6'd63, 6'd63, 1'b0, 1'b1}},
        '{ACT_HOST_WR, 8'h43,   7'd1,  1'b1, '{ST_FULL,  8'h00,   6'd63, 6'd63, 1'b0, 1'b1}},
        '{ACT_HOST_RD, 8'h00,   7'd63, 1'b0, '0},
        '{ACT_TX_RDY,  8'h00,   7'd63, 1'b0, '0},
        '{ACT_LINE_RX, CHAR_CR, 7'd1,  1'b1, '{ST_DONE,  8'h00,   6'd1,  6'd0,  1'b1, 1'b0}},
        '{ACT_HOST_RD, 8'h00,   7'd1,  1'b1, '{ST_DONE,  CHAR_LF, 6'd0,  6'd0,  1'b1, 1'b0}}
    };

    uart_crlf_ring_buffers #(
        .RX_DEPTH (RING_DEPTH),
        .TX_DEPTH (RING_DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_req   (o_out_req)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Compute the result of one accepted request and advance both rings
    function automatic t_out_req uart_rings_next(input t_in_req r);
        t_out_req         res;
        logic [LVL_W-1:0] nxt;
        logic [LVL_W-1:0] tx_used;
        res        = '0;
        res.status = ST_DONE;
        case (r.action)
            ACT_LINE_RX: begin
                nxt = rx_wr + 6'd1;
                if (nxt == rx_rd) begin
                    res.status = ST_FULL;
                end else begin
                    rx_mem[rx_wr] = r.data_in;
                    rx_wr         = nxt;
                end
            end
            ACT_HOST_WR: begin
                tx_used = tx_wr - tx_rd;
                // A LF takes two slots (CR first) or none at all
                if ((r.data_in == CHAR_LF) ? (tx_used > 6'd61) : (tx_used > 6'd62)) begin
                    res.status = ST_FULL;
                end else begin
                    if (r.data_in == CHAR_LF) begin
                        tx_mem[tx_wr] = CHAR_CR;
                        tx_wr         = tx_wr + 6'd1;
                    end
                    tx_mem[tx_wr] = r.data_in;
                    tx_wr         = tx_wr + 6'd1;
                end
            end
            ACT_HOST_RD: begin
                if (rx_rd == rx_wr) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.data_out = (rx_mem[rx_rd] == CHAR_CR) ? CHAR_LF : rx_mem[rx_rd];
                    rx_rd        = rx_rd + 6'd1;
                end
            end
            default: begin
                if (tx_rd == tx_wr) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.data_out = tx_mem[tx_rd];
                    tx_rd        = tx_rd + 6'd1;
                end
            end
        endcase
        nxt                = rx_wr + 6'd1;
        res.rx_level       = rx_wr - rx_rd;
        res.tx_level       = tx_wr - tx_rd;
        res.rx_irq_enable  = (nxt != rx_rd);
        res.tx_irq_enable  = (tx_rd != tx_wr);
        return res;
    endfunction

    // Bias line data towards CR, LF and the byte extremes
    function automatic logic [DATA_W-1:0] rand_byte();
        case ($urandom_range(7))
            0:       return CHAR_LF;
            1:       return CHAR_CR;
            2:       return $urandom_range(1) ? 8'h00 : 8'hff;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic report(input string what, input int got, input int want);
        err_cnt++;
        $display("MISMATCH t=%0t %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    // Present one request, hold it until accepted, then record its result.
    // A hand-typed result, where given, stands in for the predicted one.
    task automatic send_request(input t_in_req r, input logic typed, input t_out_req want);
        t_out_req pred;
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= r;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        pred = uart_rings_next(r);
        expected_results.push_back(typed ? want : pred);
        action_cnt[r.action]++;
        if (pred.status == ST_FULL) full_cnt++;
        if (pred.status == ST_EMPTY) empty_cnt++;
    endtask

    // Drop valid and hold off until every outstanding result has come back
    task automatic settle();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    // Random requests in segments that lean towards filling, draining or
    // neither, so that both rings swing between empty and full
    task automatic run_random(input int n_items, input int send_idle, input int recv_idle);
        t_in_req r;
        int      fill_pct;
        int      seg_left;
        in_idle_pct  = send_idle;
        out_idle_pct = recv_idle;
        fill_pct     = 50;
        seg_left     = 0;
        for (int n = 0; n < n_items; n++) begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(200, 40);
                case ($urandom_range(3))
                    0:       fill_pct = 8;
                    1:       fill_pct = 92;
                    default: fill_pct = 50;
                endcase
            end
            seg_left--;
            r.data_in = rand_byte();
            if ($urandom_range(1)) begin
                r.action = ($urandom_range(99) < fill_pct) ? ACT_LINE_RX : ACT_HOST_RD;
            end else begin
                r.action = ($urandom_range(99) < fill_pct) ? ACT_HOST_WR : ACT_TX_RDY;
            end
            // Now and then let the block run dry before carrying on
            if ($urandom_range(199) == 0) settle();
            send_request(r, 1'b0, '0);
        end
        settle();
    endtask

    // Receiver side: stall at the rate of the current phase
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < out_idle_pct);
    end

    // Check every delivered result against the oldest expectation
    always @(posedge i_clk) begin
        t_out_req want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            checked_cnt++;
            if (expected_results.size() == 0) begin
                report("result with nothing expected", o_out_req, 0);
            end else begin
                want = expected_results.pop_front();
                if (o_out_req.status !== want.status)
                    report("status", o_out_req.status, want.status);
                if (o_out_req.data_out !== want.data_out)
                    report("data_out", o_out_req.data_out, want.data_out);
                if (o_out_req.rx_level !== want.rx_level)
                    report("rx_level", o_out_req.rx_level, want.rx_level);
                if (o_out_req.tx_level !== want.tx_level)
                    report("tx_level", o_out_req.tx_level, want.tx_level);
                if (o_out_req.rx_irq_enable !== want.rx_irq_enable)
                    report("rx_irq_enable", o_out_req.rx_irq_enable, want.rx_irq_enable);
                if (o_out_req.tx_irq_enable !== want.tx_irq_enable)
                    report("tx_irq_enable", o_out_req.tx_irq_enable, want.tx_irq_enable);
            end
        end
    end

    // Watchdog: end a hung run
    initial begin
        int cyc;
        cyc = 0;
        while (cyc < WATCHDOG) begin
            @(posedge i_clk);
            cyc++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cyc, expected_results.size());
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        t_in_req r;
        foreach (action_cnt[a]) action_cnt[a] = 0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_req    <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table under the first idling mix
        in_idle_pct  = 32;
        out_idle_pct = 62;
        foreach (DIR_TAB[i]) begin
            r.action  = DIR_TAB[i].action;
            r.data_in = DIR_TAB[i].data_in;
            for (int k = 0; k < DIR_TAB[i].reps; k++) begin
                send_request(r, DIR_TAB[i].typed, DIR_TAB[i].want);
            end
        end
        settle();

        run_random(510, 32, 62);
        run_random(510, 62, 32);
        run_random(510, 0, 0);

        // Allow for any stray result beyond the last expected one
        repeat (8) @(posedge i_clk);
        if (expected_results.size() != 0)
            report("results never delivered", expected_results.size(), 0);

        $display("covered %0d line bytes, %0d host writes, %0d host reads, %0d tx ticks",
                 action_cnt[ACT_LINE_RX], action_cnt[ACT_HOST_WR],
                 action_cnt[ACT_HOST_RD], action_cnt[ACT_TX_RDY]);
        $display("%0d results checked, %0d full-ring refusals, %0d empty-ring answers, %0d errors",
                 checked_cnt, full_cnt, empty_cnt, err_cnt);
        if (err_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: uart_crlf_ring_buffers.f
design/ucrb_pkg.sv
design/ucrb_ram.sv
design/ucrb_ring.sv
design/uart_crlf_ring_buffers.sv
dv/testbench.sv
